// ===== sv/smooth_weighted_round_robin_unit_assert.svh =====
// Assertion macros for the smooth weighted round-robin unit.
`ifndef SMOOTH_WEIGHTED_ROUND_ROBIN_UNIT_ASSERT_SVH
`define SMOOTH_WEIGHTED_ROUND_ROBIN_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SWRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swrr assertion failed");

// Next-cycle implication, checked out of reset.
`define SWRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swrr assertion failed");

`endif

// ===== sv/swrr_pkg.sv =====
// Shared types and constants for the smooth weighted round-robin unit.
package swrr_pkg;

    localparam int ENDPOINTS = 8;
    localparam int SLOTS     = 8;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 4;
    localparam int WGT_W     = 8;
    localparam int RW_W      = 13;
    localparam int TOTAL_W   = 12;

    localparam logic signed [RW_W-1:0] RW_MAX = 13'sd4095;
    localparam logic signed [RW_W-1:0] RW_MIN = -13'sd4096;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENDPOINTS);

    typedef logic signed [RW_W-1:0] rw_t;

    typedef enum logic [1:0] {
        KIND_PICK   = 2'd0,
        KIND_UNHLTH = 2'd1,
        KIND_HLTH   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_WEIGHTS = 2'd0,
        REG_COUNT   = 2'd1,
        REG_HEALTH  = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_SUB  = 3'b100
    } state_t;

endpackage

// ===== sv/swrr_alu.sv =====
// Shared saturating adder used for both weight adds and the winner subtract.
module swrr_alu
    import swrr_pkg::*;
(
    input  rw_t a,
    input  rw_t b,
    output rw_t sum
);

    logic signed [RW_W:0] wide;

    always_comb
    begin
        wide = {a[RW_W-1], a} + {b[RW_W-1], b};
        priority if (wide > $signed({RW_MAX[RW_W-1], RW_MAX}))
        begin
            sum = RW_MAX;
        end
        else if (wide < $signed({RW_MIN[RW_W-1], RW_MIN}))
        begin
            sum = RW_MIN;
        end
        else
        begin
            sum = wide[RW_W-1:0];
        end
    end

endmodule

// ===== sv/smooth_weighted_round_robin_unit.sv =====
// Top level of the smooth weighted round-robin selector: sequencer and state.
//
// Input channel (in_valid/in_ready, kind, endpoint): one beat per item.
// Mark items (kind 1 clear health, kind 2 set health) finish at the accept
// edge and give no result; kind 3 is dropped. A pick walks the endpoints in
// use one per cycle through a single saturating adder, tracking the largest
// running weight, then subtracts the healthy-weight sum from the winner in
// the subtract state. A pick holds in_ready low through its scan and
// subtract states, the scan covering the effective endpoint count N (1..8),
// and its result beat (out_valid, found, chosen) is registered as it leaves
// the subtract state, so a new item waits until the pick is done.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, a following pick holds in its subtract
// state until the output register frees up.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write only while idle. Index 2 reloads the health mask.
// Reset: weights all 1, count 8, all healthy, running weights 0, no result.
module smooth_weighted_round_robin_unit
    import swrr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [IDX_W-1:0]   endpoint,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [IDX_W-1:0]   chosen,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    `include "smooth_weighted_round_robin_unit_assert.svh"

    logic [SLOTS*WGT_W-1:0] weights_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [SLOTS-1:0]       health_reg;
    rw_t                    rw_reg [SLOTS];

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   best_ok_reg, best_ok_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    rw_t                    best_val_reg, best_val_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       chosen_reg, chosen_next;

    logic [CNT_W-1:0]       n_eff;
    logic                   in_acc;
    logic                   cfg_acc;
    logic                   out_free;
    logic [IDX_W-1:0]       rd_addr;
    rw_t                    rd_data;
    logic [WGT_W-1:0]       w_raw;
    logic [WGT_W-1:0]       w_eff;
    rw_t                    alu_b;
    rw_t                    alu_sum;
    logic                   rw_we;
    logic                   last_idx;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign chosen    = chosen_reg;

    always_comb
    begin
        priority if (count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (count_reg > CNT_MAX)
        begin
            n_eff = CNT_MAX;
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    // one read port into the running weights: scan index, or winner at the end
    assign rd_addr  = (state_reg == S_SUB) ? best_idx_reg : idx_reg;
    assign rd_data  = rw_reg[rd_addr];
    assign w_raw    = weights_reg[WGT_W*idx_reg +: WGT_W];
    assign w_eff    = (w_raw == '0) ? WGT_W'(1) : w_raw;
    assign last_idx = ({1'b0, idx_reg} == (n_eff - CNT_W'(1)));

    always_comb
    begin
        if (state_reg == S_SUB)
        begin
            alu_b = -$signed({1'b0, total_reg});
        end
        else
        begin
            alu_b = $signed({{(RW_W-WGT_W){1'b0}}, w_eff});
        end
    end

    swrr_alu u_alu
    (
        .a   (rd_data),
        .b   (alu_b),
        .sum (alu_sum)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        best_ok_next   = best_ok_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        chosen_next    = chosen_reg;
        rw_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && kind == KIND_PICK)
                begin
                    state_next    = S_SCAN;
                    idx_next      = '0;
                    total_next    = '0;
                    best_ok_next  = 1'b0;
                    best_idx_next = '0;
                end
            end
            S_SCAN:
            begin
                if (health_reg[idx_reg])
                begin
                    rw_we      = 1'b1;
                    total_next = total_reg + TOTAL_W'(w_eff);
                    if (!best_ok_reg || alu_sum > best_val_reg)
                    begin
                        best_ok_next  = 1'b1;
                        best_idx_next = idx_reg;
                        best_val_next = alu_sum;
                    end
                end
                if (last_idx)
                begin
                    state_next = S_SUB;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_SUB:
            begin
                if (out_free)
                begin
                    rw_we          = best_ok_reg;
                    out_valid_next = 1'b1;
                    found_next     = best_ok_reg;
                    chosen_next    = best_ok_reg ? best_idx_reg : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            weights_reg   <= {SLOTS{WGT_W'(1)}};
            count_reg     <= CNT_MAX;
            health_reg    <= '1;
            for (int i = 0; i < SLOTS; i++)
            begin
                rw_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (rw_we)
            begin
                rw_reg[rd_addr] <= alu_sum;
            end
            if (cfg_acc)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_WEIGHTS: weights_reg <= cfg_data;
                    REG_COUNT:   count_reg   <= cfg_data[CNT_W-1:0];
                    REG_HEALTH:  health_reg  <= cfg_data[SLOTS-1:0];
                    REG_NONE:    ;
                    default:     ;
                endcase
            end
            else if (in_acc && ({1'b0, endpoint} < n_eff))
            begin
                if (kind == KIND_UNHLTH)
                begin
                    health_reg[endpoint] <= 1'b0;
                end
                else if (kind == KIND_HLTH)
                begin
                    health_reg[endpoint] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        total_reg    <= total_next;
        best_ok_reg  <= best_ok_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        found_reg    <= found_next;
        chosen_reg   <= chosen_next;
    end

    `SWRR_ASSERT_NEXT(a_pick_busy, in_acc && kind == KIND_PICK, !in_ready)
    `SWRR_ASSERT_NEXT(a_sub_done, state_reg == S_SUB && out_free, in_ready && out_valid)
    `SWRR_ASSERT_NOW(a_scan_range, state_reg == S_SCAN, {1'b0, idx_reg} < n_eff)
    `SWRR_ASSERT_NOW(a_none_zero, out_valid && !found, chosen == '0)

endmodule

// ===== verif/swrr_pick_monitor.sv =====
// Pick monitor: tracks weighted round-robin state, predicts and checks every pick result.
`timescale 1ns / 1ps
module swrr_pick_monitor
    import swrr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [1:0]       kind,
    input  logic [IDX_W-1:0] endpoint,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic             found,
    input  logic [IDX_W-1:0] chosen,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    output int               mismatches,
    output int               picks_pending
);

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] chosen;
    } pick_result_t;

    logic [63:0]      weight_table;
    logic [CNT_W-1:0] endpoint_count;
    logic [SLOTS-1:0] healthy;
    rw_t              running [SLOTS];
    pick_result_t     expected_picks [$];

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int live_endpoints(input logic [CNT_W-1:0] cnt);
        int n;
        n = int'(cnt);
        if (n < 1)
            n = 1;
        if (n > ENDPOINTS)
            n = ENDPOINTS;
        return n;
    endfunction

    function automatic int weight_of(input int idx);
        logic [WGT_W-1:0] w;
        w = weight_table[WGT_W*idx +: WGT_W];
        return (w == '0) ? 1 : int'(w);
    endfunction

    function automatic rw_t clamp_rw(input int v);
        if (v > int'(RW_MAX))
            return RW_MAX;
        if (v < int'(RW_MIN))
            return RW_MIN;
        return rw_t'(v);
    endfunction

    // Add weights of healthy endpoints in use, pick the largest (lowest index on
    // ties), charge the winner the healthy-weight sum.
    task automatic predict_pick(output pick_result_t res);
        int n;
        int total;
        int best;
        int w;
        n = live_endpoints(endpoint_count);
        total = 0;
        best = -1;
        for (int i = 0; i < n; i++)
        begin
            if (healthy[i])
            begin
                w = weight_of(i);
                running[i] = clamp_rw(int'(running[i]) + w);
                total += w;
                if (best < 0 || running[i] > running[best])
                    best = i;
            end
        end
        res.found = 1'b0;
        res.chosen = '0;
        if (best >= 0)
        begin
            running[best] = clamp_rw(int'(running[best]) - total);
            res.found = 1'b1;
            res.chosen = IDX_W'(best);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        pick_result_t want;
        pick_result_t got;
        if (!rst_n)
        begin
            weight_table = 64'h0101_0101_0101_0101;
            endpoint_count = CNT_MAX;
            healthy = '1;
            for (int i = 0; i < SLOTS; i++)
                running[i] = '0;
            expected_picks.delete();
            picks_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.found = found;
                got.chosen = chosen;
                if (expected_picks.size() == 0)
                    report_mismatch($sformatf("result beat with nothing expected: found %0d chosen %0d",
                                              got.found, got.chosen));
                else
                begin
                    want = expected_picks.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found mismatch: got %0d expected %0d",
                                                  got.found, want.found));
                    if (got.chosen !== want.chosen)
                        report_mismatch($sformatf("chosen mismatch: got %0d expected %0d",
                                                  got.chosen, want.chosen));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_WEIGHTS: weight_table = cfg_data;
                    REG_COUNT:   endpoint_count = cfg_data[CNT_W-1:0];
                    REG_HEALTH:  healthy = cfg_data[SLOTS-1:0];
                    default:     ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                case (kind_t'(kind))
                    KIND_PICK:
                    begin
                        predict_pick(want);
                        expected_picks = {expected_picks, want};
                    end
                    KIND_UNHLTH:
                        if (int'(endpoint) < live_endpoints(endpoint_count))
                            healthy[endpoint] = 1'b0;
                    KIND_HLTH:
                        if (int'(endpoint) < live_endpoints(endpoint_count))
                            healthy[endpoint] = 1'b1;
                    default: ;
                endcase
            end

            picks_pending <= expected_picks.size();
        end
    end

endmodule

// ===== verif/smooth_weighted_round_robin_unit_test.sv =====
// Testbench top: stimulus, handshake pacing and verdict for the weighted round-robin unit.
`timescale 1ns / 1ps
module smooth_weighted_round_robin_unit_test;
    import swrr_pkg::*;

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int SETTLE_CYCLES   = ENDPOINTS + 4;
    localparam int WATCHDOG_LIMIT  = 1000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       kind;
    logic [IDX_W-1:0] endpoint;
    logic             out_valid;
    logic             out_ready;
    logic             found;
    logic [IDX_W-1:0] chosen;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [63:0]      cfg_data;

    int mismatches;
    int picks_pending;
    int idle_cycles;
    int live_count;
    int gap_odds;
    int stall_odds;
    int items_done;

    smooth_weighted_round_robin_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .endpoint  (endpoint),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .chosen    (chosen),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    swrr_pick_monitor monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .endpoint      (endpoint),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .chosen        (chosen),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .picks_pending (picks_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: random stall bursts, odds set per phase.
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < stall_odds)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("smooth_weighted_round_robin_unit verification failed");
            $finish;
        end
    end

    function automatic int clamp_count(input logic [CNT_W-1:0] cnt);
        if (cnt == '0)
            return 1;
        if (int'(cnt) > ENDPOINTS)
            return ENDPOINTS;
        return int'(cnt);
    endfunction

    // One beat on the item channel; valid stays up after the beat until the
    // next negedge decides whether to drop it or present the next item.
    task automatic send_item(input kind_t k, input logic [IDX_W-1:0] ep);
        @(negedge clk);
        if ($urandom_range(0, 99) < gap_odds)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid = 1'b1;
        kind = k;
        endpoint = ep;
        do
            @(posedge clk);
        while (!in_ready);
        if (k == KIND_PICK || (k != KIND_NONE && int'(ep) < live_count))
            items_done++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (picks_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        wait_drained();
        // marks leave no result, so give any trailing work time to finish
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == REG_COUNT)
            live_count = clamp_count(val[CNT_W-1:0]);
    endtask

    function automatic logic [63:0] random_weights();
        logic [63:0] w;
        for (int b = 0; b < SLOTS; b++)
        begin
            case ($urandom_range(0, 3))
                0:       w[WGT_W*b +: WGT_W] = 8'h00;
                1:       w[WGT_W*b +: WGT_W] = 8'hFF;
                2:       w[WGT_W*b +: WGT_W] = 8'($urandom_range(1, 8));
                default: w[WGT_W*b +: WGT_W] = 8'($urandom);
            endcase
        end
        return w;
    endfunction

    function automatic kind_t random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return KIND_PICK;
        if (r < 76)
            return KIND_UNHLTH;
        if (r < 96)
            return KIND_HLTH;
        return KIND_NONE;
    endfunction

    initial
    begin
        kind_t            k;
        logic [IDX_W-1:0] ep;
        int               attempt;
        int               phase_start;

        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_PICK;
        endpoint = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WEIGHTS;
        cfg_data = '0;
        idle_cycles = 0;
        live_count = ENDPOINTS;
        gap_odds = 20;
        stall_odds = 15;
        items_done = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, health marks, kind 3, count extremes,
        // no healthy endpoint, unused register index.
        send_item(KIND_PICK, 3'd0);
        send_item(KIND_PICK, 3'd7);
        send_item(KIND_NONE, 3'd7);
        send_item(KIND_UNHLTH, 3'd7);
        send_item(KIND_UNHLTH, 3'd0);
        send_item(KIND_PICK, 3'd5);
        send_item(KIND_HLTH, 3'd7);
        send_item(KIND_HLTH, 3'd0);
        send_item(KIND_PICK, 3'd2);
        write_reg(REG_WEIGHTS, 64'hFF01_0000_0000_0080);
        write_reg(REG_COUNT, 64'd0);
        send_item(KIND_PICK, 3'd0);
        send_item(KIND_UNHLTH, 3'd3);
        send_item(KIND_PICK, 3'd4);
        write_reg(REG_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_PICK, 3'd1);
        send_item(KIND_PICK, 3'd6);
        write_reg(REG_HEALTH, 64'd0);
        send_item(KIND_PICK, 3'd0);
        send_item(KIND_HLTH, 3'd6);
        send_item(KIND_PICK, 3'd0);
        write_reg(REG_NONE, {$urandom, $urandom});
        write_reg(REG_HEALTH, 64'hFF);
        send_item(KIND_PICK, 3'd3);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_WEIGHTS, '1);
                    write_reg(REG_COUNT, 64'd8);
                    write_reg(REG_HEALTH, 64'hFF);
                end
                1:
                begin
                    write_reg(REG_WEIGHTS, '0);
                    write_reg(REG_COUNT, 64'd1);
                end
                2:
                begin
                    write_reg(REG_WEIGHTS, random_weights());
                    write_reg(REG_COUNT, 64'd0);
                end
                3:
                    write_reg(REG_COUNT, 64'hF);
                default:
                begin
                    write_reg(REG_WEIGHTS, random_weights());
                    if ($urandom_range(0, 4) != 0)
                        write_reg(REG_COUNT, 64'($urandom_range(1, 8)));
                    else
                        write_reg(REG_COUNT, {$urandom, $urandom});
                    if ($urandom_range(0, 3) == 0)
                        write_reg(REG_HEALTH, 64'($urandom_range(0, 1) * 255));
                    else
                        write_reg(REG_HEALTH, {$urandom, $urandom});
                end
            endcase
            if (phase % 3 == 0)
                write_reg(REG_NONE, {$urandom, $urandom});

            if (phase == PHASES - 1)
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            else if (phase % 4 == 3)
            begin
                gap_odds = 0;
                stall_odds = $urandom_range(10, 40);
            end
            else
            begin
                gap_odds = $urandom_range(5, 40);
                stall_odds = $urandom_range(5, 40);
            end

            phase_start = items_done;
            attempt = 0;
            while (items_done - phase_start < ITEMS_PER_PHASE)
            begin
                k = random_kind();
                if ($urandom_range(0, 4) != 0)
                    ep = IDX_W'($urandom_range(0, live_count - 1));
                else
                    ep = IDX_W'($urandom);
                send_item(k, ep);
                attempt++;
                // in even phases, after 70 attempts, the sender holds off until every pick result is back
                if (attempt == 70 && phase % 2 == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && picks_pending == 0)
            $display("smooth_weighted_round_robin_unit verification clean");
        else
            $display("smooth_weighted_round_robin_unit verification failed");
        $finish;
    end

endmodule
